// ----- hdl/hfr_pkg.sv -----
// Shared codes and the command type passed from the front end to the back end.
`default_nettype none

package hfr_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_HEADER  = 2'd0;
    localparam op_t OP_DATA    = 2'd1;
    localparam op_t OP_READ    = 2'd2;
    localparam op_t OP_RESTART = 2'd3;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK          = 2'd0;
    localparam status_t ST_BAD_LENGTH  = 2'd1;
    localparam status_t ST_UNSUPPORTED = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        op_t         op;
        logic [7:0]  hs_type;
        logic [15:0] hs_seq;
        logic [23:0] total_length;
        logic [23:0] frag_offset;
        logic [23:0] frag_len;
        logic [7:0]  data_byte;
        logic [11:0] read_address;
        logic        total_over;   // total_length beyond the buffer
        logic        frag_over;    // offset + length beyond total_length
        logic        read_oob;     // read_address beyond the buffer
    } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/handshake_fragment_reassembler_unit.sv -----
// Top level of the handshake fragment reassembler: front end, command queue, back end.
// A header result is registered in the queue entry and then the result register; data and
// read-back also pass a registered memory read. Throughput: headers, restarts and dropped
// bytes one per cycle while the result slot is free and no clearing pass runs; a data byte
// or read holds the back end until its read returns. Reset: synchronous, active low; after
// it and on a restart or new message after any stored byte, a pass clears the received map.
`default_nettype none

module handshake_fragment_reassembler_unit
    import hfr_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [7:0]  s_hs_type,
    input  wire logic [15:0] s_hs_seq,
    input  wire logic [23:0] s_total_length,
    input  wire logic [23:0] s_frag_offset,
    input  wire logic [23:0] s_frag_len,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic [11:0] s_read_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_result_kind,
    output logic [1:0]       m_status,
    output logic             m_complete,
    output logic [7:0]       m_read_data
);

    // Classified command as it enters the queue, and as the back end sees it.
    cmd_t front_cmd;
    cmd_t q_cmd;
    logic q_valid;
    logic q_ready;

    // Classify each transfer and precompute the header length checks, so the
    // back end only compares against its latched message state.
    hfr_front #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_front (
        .s_operation   (s_operation),
        .s_hs_type     (s_hs_type),
        .s_hs_seq      (s_hs_seq),
        .s_total_length(s_total_length),
        .s_frag_offset (s_frag_offset),
        .s_frag_len    (s_frag_len),
        .s_data_byte   (s_data_byte),
        .s_read_address(s_read_address),
        .cmd           (front_cmd)
    );

    // Hold up to two commands so the input keeps taking transfers while the
    // back end waits on a memory read, a clearing pass or a stalled result.
    hfr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_cmd   (front_cmd),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_cmd  (q_cmd)
    );

    // Execute commands: latch the message, store and mark bytes, count new
    // positions, read back, and drive the registered result.
    hfr_back #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cmd        (q_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result_kind(m_result_kind),
        .m_status     (m_status),
        .m_complete   (m_complete),
        .m_read_data  (m_read_data)
    );

endmodule

`default_nettype wire

// ----- hdl/hfr_front.sv -----
// Front end: classifies an incoming item and precomputes the header length checks.
`default_nettype none

module hfr_front
    import hfr_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  wire logic [1:0]  s_operation,
    input  wire logic [7:0]  s_hs_type,
    input  wire logic [15:0] s_hs_seq,
    input  wire logic [23:0] s_total_length,
    input  wire logic [23:0] s_frag_offset,
    input  wire logic [23:0] s_frag_len,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic [11:0] s_read_address,
    output cmd_t             cmd
);

    localparam logic [23:0] MAX_LEN = 24'(MAX_MESSAGE_BYTES);
    localparam logic [31:0] MAX_W   = 32'(MAX_MESSAGE_BYTES);

    logic [24:0] frag_end;

    // Exact end of the fragment, one bit wider so it cannot wrap.
    assign frag_end = {1'b0, s_frag_offset} + {1'b0, s_frag_len};

    always_comb begin
        cmd.op           = s_operation;
        cmd.hs_type      = s_hs_type;
        cmd.hs_seq       = s_hs_seq;
        cmd.total_length = s_total_length;
        cmd.frag_offset  = s_frag_offset;
        cmd.frag_len     = s_frag_len;
        cmd.data_byte    = s_data_byte;
        cmd.read_address = s_read_address;
        cmd.total_over   = (s_total_length > MAX_LEN);
        cmd.frag_over    = (frag_end > {1'b0, s_total_length});
        cmd.read_oob     = (32'(s_read_address) >= MAX_W);
    end

endmodule

`default_nettype wire

// ----- hdl/hfr_queue.sv -----
// Two-entry command queue between the front end and the back end.
`default_nettype none

module hfr_queue
    import hfr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cmd_t in_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      out_cmd
);

    cmd_t       entry_reg [0:1];
    logic       head_reg, head_next;
    logic       tail_reg, tail_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_cmd   = entry_reg[head_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        head_next = pop  ? ~head_reg : head_reg;
        tail_next = push ? ~tail_reg : tail_reg;
        fill_next = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= 1'b0;
            tail_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[tail_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hfr_back.sv -----
// Back end: message state, byte store, received map and the result register.
`default_nettype none

module hfr_back
    import hfr_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_valid,
    output logic            q_ready,
    input  wire cmd_t       q_cmd,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_result_kind,
    output logic [1:0]      m_status,
    output logic            m_complete,
    output logic [7:0]      m_read_data
);

    localparam int AW = $clog2(MAX_MESSAGE_BYTES);
    localparam int CW = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_MESSAGE_BYTES - 1);
    localparam logic [CW:0]   MAX_SUM   = (CW + 1)'(MAX_MESSAGE_BYTES);

    localparam logic [1:0] S_IDLE      = 2'd0;
    localparam logic [1:0] S_MAP_WAIT  = 2'd1;
    localparam logic [1:0] S_READ_WAIT = 2'd2;
    localparam logic [1:0] S_CLEAR     = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [7:0]    type_reg, type_next;
    logic [15:0]   seq_reg, seq_next;
    logic [CW-1:0] total_reg, total_next;
    logic          active_reg, active_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic          dirty_reg, dirty_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          oob_reg, oob_next;

    logic          m_valid_reg, m_valid_next;
    logic          kind_reg;
    status_t       status_reg;
    logic          complete_reg;
    logic [7:0]    data_reg;

    logic [7:0]    store_mem [0:MAX_MESSAGE_BYTES-1];
    logic          map_mem   [0:MAX_MESSAGE_BYTES-1];
    logic [7:0]    store_rd_reg;
    logic          map_rd_reg;

    logic          store_we, store_re, map_we, map_re, map_wd;
    logic [AW-1:0] map_wa, read_addr;
    logic [31:0]   read_wide;

    logic          slot_free, emit, e_kind, newly;
    status_t       e_status;
    logic [7:0]    e_data;
    logic          hdr_bad, hdr_new, hdr_mismatch, hdr_total_diff;

    assign slot_free = !m_valid_reg || m_ready;
    assign read_wide = 32'(q_cmd.read_address);
    assign read_addr = read_wide[AW-1:0];

    always_comb begin
        hdr_bad        = q_cmd.total_over || q_cmd.frag_over;
        hdr_new        = !hdr_bad && !active_reg;
        hdr_mismatch   = !hdr_bad && active_reg &&
                         ((q_cmd.hs_type != type_reg) || (q_cmd.hs_seq != seq_reg));
        hdr_total_diff = !hdr_bad && active_reg && !hdr_mismatch &&
                         (q_cmd.total_length[CW-1:0] != total_reg);
    end

    always_comb begin
        state_next  = state_reg;
        type_next   = type_reg;
        seq_next    = seq_reg;
        total_next  = total_reg;
        active_next = active_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        dirty_next  = dirty_reg;
        clr_next    = clr_reg;
        oob_next    = oob_reg;
        q_ready     = 1'b0;
        store_we    = 1'b0;
        store_re    = 1'b0;
        map_we      = 1'b0;
        map_re      = 1'b0;
        map_wd      = 1'b0;
        map_wa      = pos_reg;
        emit        = 1'b0;
        e_kind      = KIND_STATUS;
        e_status    = ST_OK;
        e_data      = 8'd0;
        newly       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid && slot_free) begin
                    q_ready = 1'b1;
                    unique case (q_cmd.op)
                        OP_HEADER: begin
                            emit     = 1'b1;
                            rem_next = '0;
                            if (hdr_bad || hdr_total_diff) begin
                                e_status = ST_BAD_LENGTH;
                            end else if (hdr_mismatch) begin
                                e_status = ST_UNSUPPORTED;
                            end else begin
                                pos_next = q_cmd.frag_offset[AW-1:0];
                                rem_next = q_cmd.frag_len[CW-1:0];
                            end
                            if (hdr_new) begin
                                type_next   = q_cmd.hs_type;
                                seq_next    = q_cmd.hs_seq;
                                total_next  = q_cmd.total_length[CW-1:0];
                                active_next = 1'b1;
                                count_next  = '0;
                                if (dirty_reg) begin
                                    state_next = S_CLEAR;
                                    clr_next   = '0;
                                end
                            end
                        end
                        OP_DATA: begin
                            if (rem_reg != '0) begin
                                map_re     = 1'b1;
                                store_we   = 1'b1;
                                state_next = S_MAP_WAIT;
                            end
                        end
                        OP_READ: begin
                            store_re   = 1'b1;
                            oob_next   = q_cmd.read_oob;
                            state_next = S_READ_WAIT;
                        end
                        OP_RESTART: begin
                            active_next = 1'b0;
                            count_next  = '0;
                            rem_next    = '0;
                            if (dirty_reg) begin
                                state_next = S_CLEAR;
                                clr_next   = '0;
                            end
                        end
                    endcase
                end
            end
            S_MAP_WAIT: begin
                if (slot_free) begin
                    newly      = !map_rd_reg;
                    map_we     = 1'b1;
                    map_wd     = 1'b1;
                    count_next = count_reg + CW'(newly);
                    dirty_next = 1'b1;
                    pos_next   = pos_reg + AW'(1);
                    rem_next   = rem_reg - CW'(1);
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ_WAIT: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    e_kind     = KIND_READ;
                    e_data     = oob_reg ? 8'd0 : store_rd_reg;
                    state_next = S_IDLE;
                end
            end
            S_CLEAR: begin
                map_we   = 1'b1;
                map_wd   = 1'b0;
                map_wa   = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR) begin
                    dirty_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            type_reg    <= '0;
            seq_reg     <= '0;
            total_reg   <= '0;
            active_reg  <= 1'b0;
            count_reg   <= '0;
            pos_reg     <= '0;
            rem_reg     <= '0;
            dirty_reg   <= 1'b1;
            clr_reg     <= '0;
            oob_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            type_reg    <= type_next;
            seq_reg     <= seq_next;
            total_reg   <= total_next;
            active_reg  <= active_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            rem_reg     <= rem_next;
            dirty_reg   <= dirty_next;
            clr_reg     <= clr_next;
            oob_reg     <= oob_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg     <= e_kind;
            status_reg   <= e_status;
            complete_reg <= active_next && (count_next == total_next);
            data_reg     <= e_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[pos_reg] <= q_cmd.data_byte;
        end
        if (store_re) begin
            store_rd_reg <= store_mem[read_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        if (map_re) begin
            map_rd_reg <= map_mem[pos_reg];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_status      = status_reg;
    assign m_complete    = complete_reg;
    assign m_read_data   = data_reg;

    a_count_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (count_reg <= total_reg))
        else $error("received count beyond latched total");

    a_idle_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (count_reg == '0))
        else $error("received count nonzero without an active message");

    a_fragment_in_buffer: assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_reg != '0) |-> (((CW + 1)'(pos_reg) + (CW + 1)'(rem_reg)) <= MAX_SUM))
        else $error("pending fragment runs past the buffer");

    a_clear_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !q_ready)
        else $error("command taken during map clearing pass");

endmodule

`default_nettype wire

// ----- bench/tb_handshake_fragment_reassembler_unit.sv -----
// Self-checking bench for the handshake fragment reassembler: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_handshake_fragment_reassembler_unit
    import hfr_pkg::*;
();

    localparam int MAX_BYTES      = 4096;
    localparam int HALF_PERIOD    = 10;
    localparam int WATCHDOG_LIMIT = 20000;  // covers a full clearing pass several times over
    localparam int DRAIN_CYCLES   = 16;
    localparam int ITEMS_PER_PHASE = 650;

    // One input transfer, field for field as the ports carry it.
    typedef struct packed {
        op_t         op;
        logic [7:0]  hs_type;
        logic [15:0] hs_seq;
        logic [23:0] total_length;
        logic [23:0] frag_offset;
        logic [23:0] frag_len;
        logic [7:0]  data_byte;
        logic [11:0] read_address;
    } frag_item_t;

    // One result transfer.
    typedef struct packed {
        logic       kind;
        status_t    status;
        logic       complete;
        logic [7:0] read_data;
    } frag_result_t;

    // A directed row: either its result is typed in, or the predictor supplies it.
    typedef struct packed {
        frag_item_t   item;
        logic         fixed;
        logic         fixed_has;
        frag_result_t fixed_res;
    } stim_row_t;

    localparam frag_result_t NO_RESULT = '0;
    localparam frag_result_t RES_BAD   = '{KIND_STATUS, ST_BAD_LENGTH, 1'b0, 8'h00};
    localparam frag_result_t RES_UNSUP = '{KIND_STATUS, ST_UNSUPPORTED, 1'b0, 8'h00};
    localparam frag_result_t RES_OPEN  = '{KIND_STATUS, ST_OK, 1'b0, 8'h00};
    localparam frag_result_t RES_DONE  = '{KIND_STATUS, ST_OK, 1'b1, 8'h00};

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic m_ready = 1'b0;
    logic s_ready;
    logic m_valid;
    logic m_result_kind;
    logic [1:0] m_status;
    logic m_complete;
    logic [7:0] m_read_data;

    // Payload of the transfer on offer, and what the directed table says about it.
    frag_item_t   stim        = '0;
    logic         stim_fixed  = 1'b0;
    logic         stim_fhas   = 1'b0;
    frag_result_t stim_fres   = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int useful_items  = 0;   // transfers that are not silently dropped bytes
    int quiet_cycles  = 0;

    frag_result_t predicted_results[$];

    // Predictor copy of the reassembly state.
    logic [7:0]  store_mem [MAX_BYTES];
    bit          recv_map [MAX_BYTES];
    bit          ever_written [MAX_BYTES];
    int          written_addrs[$];
    bit          msg_active = 1'b0;
    logic [7:0]  lat_type   = '0;
    logic [15:0] lat_seq    = '0;
    logic [23:0] lat_total  = '0;
    int          rx_count   = 0;
    int          wr_pos     = 0;
    int          bytes_left = 0;

    always begin
        #HALF_PERIOD aclk = ~aclk;
    end

    handshake_fragment_reassembler_unit #(
        .MAX_MESSAGE_BYTES(MAX_BYTES)
    ) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (stim.op),
        .s_hs_type         (stim.hs_type),
        .s_hs_seq          (stim.hs_seq),
        .s_total_length    (stim.total_length),
        .s_frag_offset     (stim.frag_offset),
        .s_frag_len        (stim.frag_len),
        .s_data_byte       (stim.data_byte),
        .s_read_address    (stim.read_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_status          (m_status),
        .m_complete        (m_complete),
        .m_read_data       (m_read_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_received_map();
        foreach (recv_map[i]) recv_map[i] = 1'b0;
        rx_count = 0;
    endfunction

    function automatic logic msg_done();
        return (msg_active && rx_count == int'(lat_total)) ? 1'b1 : 1'b0;
    endfunction

    // Apply one accepted transfer to the state; return 1 when it yields a result.
    function automatic bit reassemble_predict(input frag_item_t it, output frag_result_t r);
        logic [24:0] frag_end;
        status_t     st;
        r = '0;
        case (it.op)
            OP_HEADER: begin
                // Any unfinished fragment is abandoned by a new header.
                bytes_left = 0;
                st = ST_OK;
                frag_end = {1'b0, it.frag_offset} + {1'b0, it.frag_len};
                if (int'(it.total_length) > MAX_BYTES) begin
                    st = ST_BAD_LENGTH;
                end else if (frag_end > {1'b0, it.total_length}) begin
                    st = ST_BAD_LENGTH;
                end else if (!msg_active) begin
                    lat_type   = it.hs_type;
                    lat_seq    = it.hs_seq;
                    lat_total  = it.total_length;
                    msg_active = 1'b1;
                    clear_received_map();
                end else if (it.hs_type != lat_type || it.hs_seq != lat_seq) begin
                    st = ST_UNSUPPORTED;
                end else if (it.total_length != lat_total) begin
                    st = ST_BAD_LENGTH;
                end
                if (st == ST_OK) begin
                    wr_pos     = int'(it.frag_offset);
                    bytes_left = int'(it.frag_len);
                end
                r.kind     = KIND_STATUS;
                r.status   = st;
                r.complete = msg_done();
                return 1'b1;
            end
            OP_DATA: begin
                // Drop bytes that no accepted header announced.
                if (bytes_left == 0 || wr_pos >= MAX_BYTES) return 1'b0;
                store_mem[wr_pos] = it.data_byte;
                if (!recv_map[wr_pos]) begin
                    recv_map[wr_pos] = 1'b1;
                    rx_count++;
                end
                if (!ever_written[wr_pos]) begin
                    ever_written[wr_pos] = 1'b1;
                    written_addrs.push_back(wr_pos);
                end
                wr_pos++;
                bytes_left--;
                r.kind     = KIND_STATUS;
                r.status   = ST_OK;
                r.complete = msg_done();
                return 1'b1;
            end
            OP_READ: begin
                r.kind      = KIND_READ;
                r.status    = ST_OK;
                r.complete  = msg_done();
                r.read_data = (int'(it.read_address) < MAX_BYTES) ?
                              store_mem[it.read_address] : 8'h00;
                return 1'b1;
            end
            default: begin
                // Restart: forget the message, keep the stored bytes.
                msg_active = 1'b0;
                clear_received_map();
                bytes_left = 0;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Item builders: don't-care fields get random values so every bit toggles
    // ------------------------------------------------------------------

    function automatic frag_item_t noise_item();
        frag_item_t it;
        it.op           = op_t'($urandom_range(0, 3));
        it.hs_type      = 8'($urandom_range(0, 255));
        it.hs_seq       = 16'($urandom_range(0, 65535));
        it.total_length = 24'($urandom_range(0, 24'hFFFFFF));
        it.frag_offset  = 24'($urandom_range(0, 24'hFFFFFF));
        it.frag_len     = 24'($urandom_range(0, 24'hFFFFFF));
        it.data_byte    = 8'($urandom_range(0, 255));
        it.read_address = 12'($urandom_range(0, 4095));
        return it;
    endfunction

    function automatic frag_item_t header_item(input logic [7:0] ty, input logic [15:0] sq,
                                               input logic [23:0] tot, input logic [23:0] off,
                                               input logic [23:0] len);
        frag_item_t it;
        it = noise_item();
        it.op           = OP_HEADER;
        it.hs_type      = ty;
        it.hs_seq       = sq;
        it.total_length = tot;
        it.frag_offset  = off;
        it.frag_len     = len;
        return it;
    endfunction

    function automatic frag_item_t data_item(input logic [7:0] b);
        frag_item_t it;
        it = noise_item();
        it.op        = OP_DATA;
        it.data_byte = b;
        return it;
    endfunction

    function automatic frag_item_t read_item(input logic [11:0] a);
        frag_item_t it;
        it = noise_item();
        it.op           = OP_READ;
        it.read_address = a;
        return it;
    endfunction

    function automatic frag_item_t restart_item();
        frag_item_t it;
        it = noise_item();
        it.op = OP_RESTART;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one transfer at a falling edge, hold it until accepted
    // ------------------------------------------------------------------

    task automatic drive(input frag_item_t it, input logic fixed, input logic fhas,
                         input frag_result_t fres);
        // Idle the channel at random first.
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        stim       <= it;
        stim_fixed <= fixed;
        stim_fhas  <= fhas;
        stim_fres  <= fres;
        s_valid    <= 1'b1;
        // Hold valid and payload until the transfer happens.
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Receiver: stall at random, one decision per falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("t=%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: check results first, then predict the transfer taken this edge
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : scoreboard
        frag_result_t want;
        frag_result_t got_pred;
        bit           has_pred;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    mismatches++;
                    $display("t=%0t result with nothing pending: expected none actual %0h/%0h/%0h/%0h",
                             $time, m_result_kind, m_status, m_complete, m_read_data);
                end else begin
                    want = predicted_results.pop_front();
                    check_field("result_kind", 8'(want.kind), 8'(m_result_kind));
                    check_field("status", 8'(want.status), 8'(m_status));
                    check_field("complete", 8'(want.complete), 8'(m_complete));
                    check_field("read_data", want.read_data, m_read_data);
                end
            end
            if (s_valid && s_ready) begin
                has_pred = reassemble_predict(stim, got_pred);
                if (has_pred || stim.op != OP_DATA) useful_items++;
                // Typed-in rows override the predictor's result, never its state.
                if (stim_fixed) begin
                    has_pred = stim_fhas;
                    got_pred = stim_fres;
                end
                if (has_pred) predicted_results.push_back(got_pred);
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        stim_row_t   rows[$];
        frag_item_t  broken;
        logic [7:0]  cur_type;
        logic [15:0] cur_seq;
        int          cur_total;
        int          cursor;
        int          off;
        int          span;
        int          len;
        int          nbytes;
        int          pick;
        int          variant;

        // Directed table. Rows with a typed-in result are plain to read off the spec;
        // the rest go through the predictor.
        // Stray byte straight after reset: dropped.
        rows.push_back('{data_item(8'h77), 1'b1, 1'b0, NO_RESULT});
        // Length checks: total over the buffer, then fragment past the total.
        rows.push_back('{header_item(8'h01, 16'h0001, 24'hFFFFFF, 24'd0, 24'd0),
                         1'b1, 1'b1, RES_BAD});
        rows.push_back('{header_item(8'h01, 16'h0001, 24'd4097, 24'd0, 24'd0),
                         1'b1, 1'b1, RES_BAD});
        rows.push_back('{header_item(8'h01, 16'h0001, 24'd10, 24'd8, 24'd3),
                         1'b1, 1'b1, RES_BAD});
        rows.push_back('{header_item(8'h00, 16'h0000, 24'd100, 24'hFFFFFF, 24'hFFFFFF),
                         1'b1, 1'b1, RES_BAD});
        // Zero-length message completes on its first header.
        rows.push_back('{header_item(8'hFF, 16'hFFFF, 24'd0, 24'd0, 24'd0),
                         1'b1, 1'b1, RES_DONE});
        rows.push_back('{restart_item(), 1'b1, 1'b0, NO_RESULT});
        // Six-byte message: first half.
        rows.push_back('{header_item(8'h5A, 16'h1234, 24'd6, 24'd0, 24'd3),
                         1'b1, 1'b1, RES_OPEN});
        rows.push_back('{data_item(8'h00), 1'b0, 1'b0, NO_RESULT});
        rows.push_back('{data_item(8'hFF), 1'b0, 1'b0, NO_RESULT});
        rows.push_back('{data_item(8'hA5), 1'b0, 1'b0, NO_RESULT});
        // Mismatches against the latched header; the byte after a rejected header drops.
        rows.push_back('{header_item(8'h5B, 16'h1234, 24'd6, 24'd3, 24'd3),
                         1'b1, 1'b1, RES_UNSUP});
        rows.push_back('{data_item(8'h11), 1'b1, 1'b0, NO_RESULT});
        rows.push_back('{header_item(8'h5A, 16'h1235, 24'd6, 24'd3, 24'd3),
                         1'b1, 1'b1, RES_UNSUP});
        rows.push_back('{header_item(8'h5A, 16'h1234, 24'd7, 24'd3, 24'd3),
                         1'b1, 1'b1, RES_BAD});
        // Fragment cut short by an overlapping header, then completed.
        rows.push_back('{header_item(8'h5A, 16'h1234, 24'd6, 24'd3, 24'd3),
                         1'b0, 1'b0, NO_RESULT});
        rows.push_back('{data_item(8'h3C), 1'b0, 1'b0, NO_RESULT});
        rows.push_back('{header_item(8'h5A, 16'h1234, 24'd6, 24'd2, 24'd4),
                         1'b0, 1'b0, NO_RESULT});
        rows.push_back('{data_item(8'hC3), 1'b0, 1'b0, NO_RESULT});
        rows.push_back('{data_item(8'h5A), 1'b0, 1'b0, NO_RESULT});
        rows.push_back('{data_item(8'h96), 1'b0, 1'b0, NO_RESULT});
        rows.push_back('{data_item(8'h69), 1'b0, 1'b0, NO_RESULT});
        rows.push_back('{read_item(12'd0), 1'b0, 1'b0, NO_RESULT});
        // Stored bytes survive a restart.
        rows.push_back('{restart_item(), 1'b1, 1'b0, NO_RESULT});
        rows.push_back('{read_item(12'd1), 1'b0, 1'b0, NO_RESULT});
        // Last buffer position, largest legal total.
        rows.push_back('{header_item(8'h80, 16'h8000, 24'd4096, 24'd4095, 24'd1),
                         1'b0, 1'b0, NO_RESULT});
        rows.push_back('{data_item(8'hE7), 1'b0, 1'b0, NO_RESULT});
        rows.push_back('{read_item(12'hFFF), 1'b0, 1'b0, NO_RESULT});

        foreach (store_mem[i]) store_mem[i] = 8'h00;
        foreach (ever_written[i]) ever_written[i] = 1'b0;
        foreach (recv_map[i]) recv_map[i] = 1'b0;
        cur_type  = '0;
        cur_seq   = '0;
        cur_total = 0;
        cursor    = 0;

        // Hold reset, then release it on a falling edge.
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 84;
        foreach (rows[i]) drive(rows[i].item, rows[i].fixed, rows[i].fixed_has, rows[i].fixed_res);

        // Random traffic in three phases of idling: sender light/receiver heavy,
        // then swapped, then none at all.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 84 : 0;
            recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 26 : 0;
            while (useful_items < (phase + 1) * ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                // Mostly abandon a finished message so a new one can start.
                if (msg_done() && $urandom_range(0, 99) < 60) pick = 99;

                if (pick < 60) begin
                    // Well-formed fragment of the current or a fresh message.
                    if (msg_active) begin
                        cur_type  = lat_type;
                        cur_seq   = lat_seq;
                        cur_total = int'(lat_total);
                    end else begin
                        cur_type  = 8'($urandom_range(0, 255));
                        cur_seq   = 16'($urandom_range(0, 65535));
                        cur_total = ($urandom_range(0, 9) == 0) ?
                                    $urandom_range(49, MAX_BYTES) : $urandom_range(0, 48);
                        cursor    = 0;
                    end
                    if (cursor >= cur_total) cursor = 0;
                    off = ($urandom_range(0, 5) == 0) ? $urandom_range(0, cur_total) : cursor;
                    span = cur_total - off;
                    if (span > 16) span = 16;
                    len = (span == 0) ? 0 :
                          $urandom_range(($urandom_range(0, 7) == 0) ? 0 : 1, span);
                    drive(header_item(cur_type, cur_seq, 24'(cur_total), 24'(off), 24'(len)),
                          1'b0, 1'b0, NO_RESULT);
                    cursor = off + len;
                    // Usually the full payload; sometimes cut short or overrun.
                    nbytes = len;
                    variant = $urandom_range(0, 7);
                    if (variant == 0) nbytes = $urandom_range(0, len);
                    else if (variant == 1) nbytes = len + $urandom_range(1, 3);
                    repeat (nbytes) drive(data_item(8'($urandom_range(0, 255))),
                                          1'b0, 1'b0, NO_RESULT);
                end else if (pick < 75) begin
                    // Read back only positions that hold a written byte.
                    if (written_addrs.size() != 0) begin
                        drive(read_item(12'(written_addrs[$urandom_range(0,
                                                           written_addrs.size() - 1)])),
                              1'b0, 1'b0, NO_RESULT);
                    end
                end else if (pick < 87) begin
                    // Broken header, possibly followed by bytes that must drop.
                    variant = msg_active ? $urandom_range(0, 4) : 0;
                    case (variant)
                        0: begin
                            // Header with random fields; almost always a length error.
                            broken    = noise_item();
                            broken.op = OP_HEADER;
                            drive(broken, 1'b0, 1'b0, NO_RESULT);
                        end
                        1: drive(header_item(lat_type ^ 8'($urandom_range(1, 255)), lat_seq,
                                             lat_total, 24'd0, 24'd0), 1'b0, 1'b0, NO_RESULT);
                        2: drive(header_item(lat_type, lat_seq ^ 16'($urandom_range(1, 65535)),
                                             lat_total, 24'd0, 24'd0), 1'b0, 1'b0, NO_RESULT);
                        3: drive(header_item(lat_type, lat_seq,
                                             lat_total + 24'($urandom_range(1, 16)), 24'd0,
                                             24'd0), 1'b0, 1'b0, NO_RESULT);
                        default: drive(header_item(lat_type, lat_seq, lat_total, lat_total,
                                                   24'd1), 1'b0, 1'b0, NO_RESULT);
                    endcase
                    if ($urandom_range(0, 1) == 0) begin
                        drive(data_item(8'($urandom_range(0, 255))), 1'b0, 1'b0, NO_RESULT);
                    end
                end else if (pick < 96) begin
                    drive(data_item(8'($urandom_range(0, 255))), 1'b0, 1'b0, NO_RESULT);
                end else begin
                    drive(restart_item(), 1'b0, 1'b0, NO_RESULT);
                end
            end
        end

        // Drop valid, drain every pending result, then let the pipeline settle.
        s_valid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
